[design/assert_macros.svh]
// Assertion helpers clocked on clock; ASSERT_CLK is masked during reset, ASSERT_CLK_NORST is not.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("assertion failed");

`define ASSERT_CLK_NORST(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("assertion failed");

`endif

[design/phsc_pkg.sv]
package phsc_pkg;

   localparam int POS_W      = 16;
   localparam int MASS_W     = 24;
   localparam int DRV_W      = 16;
   localparam int GAIN_W     = 8;
   localparam int THR_W      = 15;
   localparam int FRAC_BITS  = 14;
   localparam int E_W        = POS_W + 1;
   localparam int PROD_W     = GAIN_W + 1 + E_W;
   localparam int D_W        = PROD_W - FRAC_BITS;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REQ_W      = POS_W + MASS_W;
   localparam int RSP_W      = 2 * DRV_W;

   localparam logic [PROD_W-1:0] FRAC_ROUND = PROD_W'((1 << FRAC_BITS) - 1);

   typedef enum logic [2:0] {
      REG_MIN_MAGNITUDE  = 3'd0,
      REG_EDGE_THRESHOLD = 3'd1,
      REG_OUTER_GAIN     = 3'd2,
      REG_INNER_GAIN     = 3'd3,
      REG_LEFT_BASE      = 3'd4,
      REG_RIGHT_BASE     = 3'd5
   } reg_index_type;

   localparam logic [MASS_W-1:0] RST_MIN_MAGNITUDE  = 24'd4096;
   localparam logic [THR_W-1:0]  RST_EDGE_THRESHOLD = 15'd8192;
   localparam logic [GAIN_W-1:0] RST_OUTER_GAIN     = 8'd70;
   localparam logic [GAIN_W-1:0] RST_INNER_GAIN     = 8'd10;
   localparam logic [GAIN_W-1:0] RST_LEFT_BASE      = 8'd70;
   localparam logic [GAIN_W-1:0] RST_RIGHT_BASE     = 8'd50;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_ACCUM = 7'b0000010,
      ST_DIV   = 7'b0000100,
      ST_SIGN  = 7'b0001000,
      ST_MUL   = 7'b0010000,
      ST_APPLY = 7'b0100000,
      ST_DONE  = 7'b1000000
   } state_type;

   function automatic logic signed [DRV_W-1:0] sat_drive(input logic signed [DRV_W:0] v);
      logic signed [DRV_W-1:0] r;
      if (v[DRV_W] != v[DRV_W-1]) begin
         r = v[DRV_W] ? {1'b1, {(DRV_W-1){1'b0}}} : {1'b0, {(DRV_W-1){1'b1}}};
      end else begin
         r = v[DRV_W-1:0];
      end
      return r;
   endfunction

endpackage

[design/pose_history_steering_control.sv]
// Channel  | Dir | Fields (low bit first)                 | Handshake
// req      | in  | position[15:0], magnitude[39:16]       | tvalid/tready
// rsp      | out | left_drive[15:0], right_drive[31:16]   | tvalid/tready
// csr      | in  | six 32-bit registers at 4*index        | APB, pready tied high
//
// Absent target: the result follows directly. Present target: one accumulate pass over
// the RING_DEPTH entries, a 1-bit/cycle divide of 16+clog2(RING_DEPTH+1) quotient bits
// (skipped when the ring is empty), then sign, multiply, saturate and output steps.
// Reset is synchronous; it empties the ring and clears the held drives.
// A stalled rsp holds the next finished frame back; req stays low until it drains.
`include "assert_macros.svh"

module pose_history_steering_control #(
   parameter int RING_DEPTH = 3
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // position[15:0], magnitude[39:16]
   input  logic [phsc_pkg::REQ_W-1:0]           req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // left_drive[15:0], right_drive[31:16]
   output logic [phsc_pkg::RSP_W-1:0]           rsp_tdata,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [phsc_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [phsc_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [phsc_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);
   import phsc_pkg::*;

   localparam int IDX_W  = $clog2(RING_DEPTH);
   localparam int CNT_W  = $clog2(RING_DEPTH + 1);
   localparam int MAG_W  = POS_W + CNT_W;
   localparam int SUM_W  = MAG_W + 1;
   localparam int STEP_W = $clog2(MAG_W);

   state_type                state_ff, state_in;
   logic signed [POS_W-1:0]  ring_ff [RING_DEPTH];
   logic signed [POS_W-1:0]  ring_in [RING_DEPTH];
   logic [IDX_W-1:0]         ptr_ff, ptr_in;
   logic signed [DRV_W-1:0]  hold_l_ff, hold_l_in, hold_r_ff, hold_r_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [MASS_W-1:0]        min_mag_ff, min_mag_in;
   logic [THR_W-1:0]         edge_thr_ff, edge_thr_in;
   logic [GAIN_W-1:0]        outer_gain_ff, outer_gain_in, inner_gain_ff, inner_gain_in;
   logic [GAIN_W-1:0]        left_base_ff, left_base_in, right_base_ff, right_base_in;

   logic signed [POS_W-1:0]  pos_ff, pos_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [STEP_W-1:0]        step_ff, step_in;
   logic [MAG_W-1:0]         quo_ff, quo_in;
   logic [CNT_W:0]           rem_ff, rem_in;
   logic                     neg_ff, neg_in;
   logic signed [E_W-1:0]    e_ff, e_in;
   logic                     edge_ff, edge_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [RSP_W-1:0]         rsp_data_ff, rsp_data_in;

   logic signed [POS_W-1:0]  req_pos, entry;
   logic [MASS_W-1:0]        req_mass;
   logic signed [E_W-1:0]    diff;
   logic signed [SUM_W-1:0]  sum_nx, sum_abs;
   logic [CNT_W-1:0]         cnt_nx;
   logic [CNT_W:0]           trial;
   logic                     qbit;
   logic [POS_W-1:0]         e_mag;
   logic signed [PROD_W-1:0] biased;
   logic signed [D_W-1:0]    d_val;
   logic signed [DRV_W:0]    left_raw, right_raw;
   logic                     csr_wr;
   logic [2:0]               csr_idx;

   assign req_pos    = req_tdata[POS_W-1:0];
   assign req_mass   = req_tdata[REQ_W-1:POS_W];
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_idx    = csr_paddr[4:2];

   always_comb begin
      unique case (csr_idx)
         REG_MIN_MAGNITUDE:  csr_prdata = CSR_DATA_W'(min_mag_ff);
         REG_EDGE_THRESHOLD: csr_prdata = CSR_DATA_W'(edge_thr_ff);
         REG_OUTER_GAIN:     csr_prdata = CSR_DATA_W'(outer_gain_ff);
         REG_INNER_GAIN:     csr_prdata = CSR_DATA_W'(inner_gain_ff);
         REG_LEFT_BASE:      csr_prdata = CSR_DATA_W'(left_base_ff);
         REG_RIGHT_BASE:     csr_prdata = CSR_DATA_W'(right_base_ff);
         default:            csr_prdata = '0;
      endcase
   end

   // shared datapath terms
   assign entry   = ring_ff[step_ff[IDX_W-1:0]];
   assign diff    = E_W'(pos_ff) - E_W'(entry);
   assign sum_nx  = (entry != '0) ? sum_ff + SUM_W'(diff) : sum_ff;
   assign cnt_nx  = (entry != '0) ? cnt_ff + CNT_W'(1) : cnt_ff;
   assign sum_abs = sum_nx[SUM_W-1] ? -sum_nx : sum_nx;
   assign trial   = {rem_ff[CNT_W-1:0], quo_ff[MAG_W-1]};
   assign qbit    = (trial >= {1'b0, cnt_ff});
   assign e_mag   = quo_ff[POS_W-1:0];
   assign biased  = prod_ff[PROD_W-1] ? prod_ff + FRAC_ROUND : prod_ff;
   assign d_val   = biased[PROD_W-1:FRAC_BITS];

   always_comb begin
      state_in      = state_ff;
      ring_in       = ring_ff;
      ptr_in        = ptr_ff;
      hold_l_in     = hold_l_ff;
      hold_r_in     = hold_r_ff;
      rsp_valid_in  = rsp_valid_ff;
      min_mag_in    = min_mag_ff;
      edge_thr_in   = edge_thr_ff;
      outer_gain_in = outer_gain_ff;
      inner_gain_in = inner_gain_ff;
      left_base_in  = left_base_ff;
      right_base_in = right_base_ff;
      pos_in        = pos_ff;
      sum_in        = sum_ff;
      cnt_in        = cnt_ff;
      step_in       = step_ff;
      quo_in        = quo_ff;
      rem_in        = rem_ff;
      neg_in        = neg_ff;
      e_in          = e_ff;
      edge_in       = edge_ff;
      prod_in       = prod_ff;
      rsp_data_in   = rsp_data_ff;
      left_raw      = '0;
      right_raw     = '0;

      if (csr_wr) begin
         unique case (csr_idx)
            REG_MIN_MAGNITUDE:  min_mag_in    = csr_pwdata[MASS_W-1:0];
            REG_EDGE_THRESHOLD: edge_thr_in   = csr_pwdata[THR_W-1:0];
            REG_OUTER_GAIN:     outer_gain_in = csr_pwdata[GAIN_W-1:0];
            REG_INNER_GAIN:     inner_gain_in = csr_pwdata[GAIN_W-1:0];
            REG_LEFT_BASE:      left_base_in  = csr_pwdata[GAIN_W-1:0];
            REG_RIGHT_BASE:     right_base_in = csr_pwdata[GAIN_W-1:0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               pos_in  = req_pos;
               ptr_in  = (ptr_ff == IDX_W'(RING_DEPTH - 1)) ? '0 : ptr_ff + IDX_W'(1);
               sum_in  = '0;
               cnt_in  = '0;
               step_in = '0;
               if (req_mass < min_mag_ff) begin
                  ring_in[ptr_ff] = '0;
                  hold_l_in       = '0;
                  hold_r_in       = '0;
                  state_in        = ST_DONE;
               end else begin
                  ring_in[ptr_ff] = req_pos;
                  state_in        = ST_ACCUM;
               end
            end
         end
         ST_ACCUM: begin
            sum_in  = sum_nx;
            cnt_in  = cnt_nx;
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(RING_DEPTH - 1)) begin
               step_in = '0;
               rem_in  = '0;
               neg_in  = sum_nx[SUM_W-1];
               if (cnt_nx == '0) begin
                  quo_in   = '0;
                  state_in = ST_SIGN;
               end else begin
                  quo_in   = sum_abs[MAG_W-1:0];
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            rem_in  = qbit ? trial - {1'b0, cnt_ff} : trial;
            quo_in  = {quo_ff[MAG_W-2:0], qbit};
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(MAG_W - 1)) begin
               state_in = ST_SIGN;
            end
         end
         ST_SIGN: begin
            e_in     = neg_ff ? -E_W'(e_mag) : E_W'(e_mag);
            edge_in  = (e_mag > POS_W'(edge_thr_ff));
            state_in = ST_MUL;
         end
         ST_MUL: begin
            prod_in  = $signed({1'b0, edge_ff ? outer_gain_ff : inner_gain_ff}) * e_ff;
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            if (edge_ff) begin
               left_raw  = (DRV_W + 1)'(hold_l_ff) - (DRV_W + 1)'(d_val);
               right_raw = (DRV_W + 1)'(hold_r_ff) + (DRV_W + 1)'(d_val);
            end else begin
               left_raw  = $signed((DRV_W + 1)'(left_base_ff)) - (DRV_W + 1)'(d_val);
               right_raw = $signed((DRV_W + 1)'(right_base_ff)) + (DRV_W + 1)'(d_val);
            end
            hold_l_in = sat_drive(left_raw);
            hold_r_in = sat_drive(right_raw);
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {hold_r_ff, hold_l_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         for (int i = 0; i < RING_DEPTH; i++) begin
            ring_ff[i] <= '0;
         end
         ptr_ff        <= '0;
         hold_l_ff     <= '0;
         hold_r_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
         min_mag_ff    <= RST_MIN_MAGNITUDE;
         edge_thr_ff   <= RST_EDGE_THRESHOLD;
         outer_gain_ff <= RST_OUTER_GAIN;
         inner_gain_ff <= RST_INNER_GAIN;
         left_base_ff  <= RST_LEFT_BASE;
         right_base_ff <= RST_RIGHT_BASE;
         step_ff       <= '0;
         cnt_ff        <= '0;
         rem_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         ring_ff       <= ring_in;
         ptr_ff        <= ptr_in;
         hold_l_ff     <= hold_l_in;
         hold_r_ff     <= hold_r_in;
         rsp_valid_ff  <= rsp_valid_in;
         min_mag_ff    <= min_mag_in;
         edge_thr_ff   <= edge_thr_in;
         outer_gain_ff <= outer_gain_in;
         inner_gain_ff <= inner_gain_in;
         left_base_ff  <= left_base_in;
         right_base_ff <= right_base_in;
         step_ff       <= step_in;
         cnt_ff        <= cnt_in;
         rem_ff        <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      sum_ff      <= sum_in;
      quo_ff      <= quo_in;
      neg_ff      <= neg_in;
      e_ff        <= e_in;
      edge_ff     <= edge_in;
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
   end

   `ASSERT_CLK(a_busy_after_req, (req_tvalid && req_tready) |=> !req_tready)
   `ASSERT_CLK(a_div_rem_bound, (state_ff == ST_DIV) |-> (rem_ff < {1'b0, cnt_ff}))
   `ASSERT_CLK(a_cnt_bound, cnt_ff <= CNT_W'(RING_DEPTH))
   `ASSERT_CLK(a_rsp_from_done, $rose(rsp_tvalid) |-> $past(state_ff == ST_DONE))

endmodule

[bench/pose_history_steering_control_test.sv]
module pose_history_steering_control_test;
   import phsc_pkg::*;

   localparam int RING_DEPTH     = 3;
   localparam int CLK_HALF       = 6;
   localparam int DRIVE_MAX      = 32767;
   localparam int DRIVE_MIN      = -32768;
   localparam int Q_ONE          = 1 << FRAC_BITS;
   localparam int POS_LIMIT      = 16384;
   localparam int MAX_GAP        = 8;
   localparam int DRAIN_CYCLES   = 40;
   localparam int HOLDOFF_CYCLES = 300;
   localparam int TIMEOUT_CYCLES = 400000;
   localparam int REG_SLOTS      = 1 << (CSR_ADDR_W - 2);

   localparam logic signed [POS_W-1:0] POS_RIGHT = 16'sd16384;
   localparam logic signed [POS_W-1:0] POS_LEFT  = -16'sd16384;
   localparam logic [MASS_W-1:0]       MASS_FULL = '1;

   // packed MSB first: left_drive sits in the low half of rsp_tdata
   typedef struct packed {
      logic signed [DRV_W-1:0] right;
      logic signed [DRV_W-1:0] left;
   } drive_pair_t;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   // position[15:0], magnitude[39:16]
   logic [REQ_W-1:0]      req_tdata   = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   // left_drive[15:0], right_drive[31:16]
   logic [RSP_W-1:0]      rsp_tdata;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   logic [MASS_W-1:0] cfg_min_mass   = RST_MIN_MAGNITUDE;
   logic [THR_W-1:0]  cfg_edge_thr   = RST_EDGE_THRESHOLD;
   logic [GAIN_W-1:0] cfg_outer_gain = RST_OUTER_GAIN;
   logic [GAIN_W-1:0] cfg_inner_gain = RST_INNER_GAIN;
   logic [GAIN_W-1:0] cfg_left_base  = RST_LEFT_BASE;
   logic [GAIN_W-1:0] cfg_right_base = RST_RIGHT_BASE;

   logic signed [POS_W-1:0] pose_hist [RING_DEPTH] = '{default: '0};
   int                      hist_ptr   = 0;
   int                      left_held  = 0;
   int                      right_held = 0;

   drive_pair_t drive_queue[$];
   int unsigned mismatches  = 0;
   bit          gapless     = 1'b0;
   int unsigned rsp_holdoff = 0;

   pose_history_steering_control #(.RING_DEPTH(RING_DEPTH)) dut (.*);

   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   function automatic int clamp_drive(input int v);
      return (v > DRIVE_MAX) ? DRIVE_MAX : ((v < DRIVE_MIN) ? DRIVE_MIN : v);
   endfunction

   function automatic drive_pair_t step_steering(input logic signed [POS_W-1:0] pos,
                                                 input logic [MASS_W-1:0] mass);
      int          sum;
      int          cnt;
      int          err;
      int          delta;
      int          i;
      drive_pair_t r;
      sum = 0;
      cnt = 0;
      err = 0;
      pose_hist[hist_ptr] = (mass < cfg_min_mass) ? '0 : pos;
      hist_ptr = (hist_ptr + 1) % RING_DEPTH;
      if (mass < cfg_min_mass) begin
         left_held  = 0;
         right_held = 0;
      end else begin
         for (i = 0; i < RING_DEPTH; i++) begin
            if (pose_hist[i] != 0) begin
               sum += int'(pos) - int'(pose_hist[i]);
               cnt++;
            end
         end
         if (cnt != 0) err = sum / cnt;
         if (((err < 0) ? -err : err) > int'(cfg_edge_thr)) begin
            delta      = int'(cfg_outer_gain) * err / Q_ONE;
            left_held  = clamp_drive(left_held - delta);
            right_held = clamp_drive(right_held + delta);
         end else begin
            delta      = int'(cfg_inner_gain) * err / Q_ONE;
            left_held  = clamp_drive(int'(cfg_left_base) - delta);
            right_held = clamp_drive(int'(cfg_right_base) + delta);
         end
      end
      r.left  = DRV_W'(left_held);
      r.right = DRV_W'(right_held);
      return r;
   endfunction

   task automatic send_frame(input logic signed [POS_W-1:0] pos,
                             input logic [MASS_W-1:0] mass);
      int unsigned gap;
      gap = gapless ? 0 : $urandom_range(0, MAX_GAP);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {mass, pos};
      do @(posedge clock); while (!(req_tvalid && req_tready));
      drive_queue.push_back(step_steering(pos, mass));
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (drive_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_read(input logic [CSR_ADDR_W-1:0] addr,
                           output logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= addr;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      data = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (addr[CSR_ADDR_W-1:2])
         REG_MIN_MAGNITUDE:  cfg_min_mass   = data[MASS_W-1:0];
         REG_EDGE_THRESHOLD: cfg_edge_thr   = data[THR_W-1:0];
         REG_OUTER_GAIN:     cfg_outer_gain = data[GAIN_W-1:0];
         REG_INNER_GAIN:     cfg_inner_gain = data[GAIN_W-1:0];
         REG_LEFT_BASE:      cfg_left_base  = data[GAIN_W-1:0];
         REG_RIGHT_BASE:     cfg_right_base = data[GAIN_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic check_registers();
      int                    k;
      logic [CSR_DATA_W-1:0] got;
      logic [CSR_DATA_W-1:0] want;
      for (k = REG_MIN_MAGNITUDE; k <= REG_RIGHT_BASE; k++) begin
         case (k)
            REG_MIN_MAGNITUDE:  want = CSR_DATA_W'(cfg_min_mass);
            REG_EDGE_THRESHOLD: want = CSR_DATA_W'(cfg_edge_thr);
            REG_OUTER_GAIN:     want = CSR_DATA_W'(cfg_outer_gain);
            REG_INNER_GAIN:     want = CSR_DATA_W'(cfg_inner_gain);
            REG_LEFT_BASE:      want = CSR_DATA_W'(cfg_left_base);
            default:            want = CSR_DATA_W'(cfg_right_base);
         endcase
         csr_read({(CSR_ADDR_W-2)'(k), 2'b00}, got);
         if (got !== want) begin
            $display("%0t: register %0d expected %0h, got %0h", $time, k, want, got);
            mismatches++;
         end
      end
   endtask

   task automatic apply_settings(input logic [MASS_W-1:0] min_mass,
                                 input logic [THR_W-1:0]  edge_thr,
                                 input logic [GAIN_W-1:0] outer_gain,
                                 input logic [GAIN_W-1:0] inner_gain,
                                 input logic [GAIN_W-1:0] left_base,
                                 input logic [GAIN_W-1:0] right_base);
      csr_write({REG_MIN_MAGNITUDE, 2'b00}, CSR_DATA_W'(min_mass));
      csr_write({REG_EDGE_THRESHOLD, 2'b00}, CSR_DATA_W'(edge_thr));
      csr_write({REG_OUTER_GAIN, 2'b00}, CSR_DATA_W'(outer_gain));
      csr_write({REG_INNER_GAIN, 2'b00}, CSR_DATA_W'(inner_gain));
      csr_write({REG_LEFT_BASE, 2'b00}, CSR_DATA_W'(left_base));
      csr_write({REG_RIGHT_BASE, 2'b00}, CSR_DATA_W'(right_base));
      check_registers();
   endtask

   // reset values, masking, and writes to unmapped slots
   task automatic test_register_access();
      int k;
      check_registers();
      for (k = REG_MIN_MAGNITUDE; k < REG_SLOTS; k++)
         csr_write({(CSR_ADDR_W-2)'(k), 2'b00}, '1);
      check_registers();
      for (k = REG_MIN_MAGNITUDE; k < REG_SLOTS; k++)
         csr_write({(CSR_ADDR_W-2)'(k), 2'b00}, $urandom());
      check_registers();
      apply_settings(RST_MIN_MAGNITUDE, RST_EDGE_THRESHOLD, RST_OUTER_GAIN,
                     RST_INNER_GAIN, RST_LEFT_BASE, RST_RIGHT_BASE);
   endtask

   task automatic test_directed_frames();
      send_frame(16'sd0, MASS_FULL);              // empty ring, e = 0
      send_frame(POS_RIGHT, RST_MIN_MAGNITUDE);   // mass at threshold counts as present
      send_frame(POS_LEFT, MASS_FULL);            // edge nudge
      send_frame(POS_RIGHT, 24'h800000);          // mean truncation, pointer wrap
      send_frame(POS_RIGHT, 24'h7FFFFF);
      send_frame(POS_LEFT, RST_MIN_MAGNITUDE - 1); // absent target
      send_frame(16'sh7FFF, '0);
      send_frame(16'sh8000, 24'h000FFF);
      send_frame(16'sd8192, MASS_FULL);
      send_frame(-16'sd8192, 24'h555555);         // |e| equal to threshold stays central
      send_frame(-16'sd1, 24'h000001);
      send_frame(16'sd1, 24'h000000);
      send_frame(16'sh5555, 24'h000AAA);
      send_frame(-16'sd8192, 24'hAAAAAA);
      send_frame(16'sd8194, MASS_FULL);           // |e| one above threshold nudges
      send_frame(16'sd0, MASS_FULL);              // zero position with history
      send_frame(-16'sd1, 24'hABCDEF);
      send_frame(16'sd1, 24'h123456);
      send_frame(16'sh2AAA, MASS_FULL);
      send_frame(-16'sh2AAA, MASS_FULL);
   endtask

   // a ring pattern whose nudges all push left up and right down until both clip
   task automatic test_drive_saturation();
      settle();
      apply_settings('0, '0, '1, '1, '0, '0);
      gapless = 1'b1;
      repeat (140) begin
         send_frame(POS_RIGHT, MASS_FULL);
         send_frame(POS_RIGHT - 16'sd2, MASS_FULL);
         send_frame(16'sd0, MASS_FULL);
      end
      gapless = 1'b0;
      settle();
   endtask

   task automatic test_output_backpressure();
      rsp_holdoff = HOLDOFF_CYCLES;
      gapless = 1'b1;
      repeat (8)
         send_frame(POS_W'(int'($urandom_range(0, 2 * POS_LIMIT)) - POS_LIMIT), MASS_FULL);
      gapless = 1'b0;
      settle();
   endtask

   task automatic test_random_traffic();
      int                phase;
      int                n;
      int                p;
      int                walk;
      logic [MASS_W-1:0] mass;
      walk = 0;
      for (phase = 0; phase < 8; phase++) begin
         settle();
         case (phase)
            0: apply_settings(RST_MIN_MAGNITUDE, RST_EDGE_THRESHOLD, RST_OUTER_GAIN,
                              RST_INNER_GAIN, RST_LEFT_BASE, RST_RIGHT_BASE);
            1: apply_settings('0, '0, '0, '0, '0, '0);
            2: apply_settings('1, '1, '1, '1, '1, '1);
            default:
               apply_settings(MASS_W'($urandom_range(0, MASS_FULL) >> $urandom_range(0, MASS_W - 1)),
                              THR_W'($urandom_range(0, 20000)),
                              GAIN_W'($urandom_range(0, 255)), GAIN_W'($urandom_range(0, 255)),
                              GAIN_W'($urandom_range(0, 255)), GAIN_W'($urandom_range(0, 255)));
         endcase
         for (n = 0; n < ((phase == 2) ? 30 : 70); n++) begin
            if (n % 35 == 0) gapless = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 9))
               0:          p = 0;
               1:          p = $urandom_range(0, 1) ? POS_LIMIT : -POS_LIMIT;
               2, 3, 4, 5: p = walk + int'($urandom_range(0, 4096)) - 2048;
               default:    p = int'($urandom_range(0, 2 * POS_LIMIT)) - POS_LIMIT;
            endcase
            if (p > POS_LIMIT) p = POS_LIMIT;
            if (p < -POS_LIMIT) p = -POS_LIMIT;
            walk = p;
            case ($urandom_range(0, 9))
               0:       mass = cfg_min_mass - 1'b1;
               1:       mass = cfg_min_mass;
               2:       mass = (cfg_min_mass == 0) ? '0 :
                               MASS_W'($urandom_range(0, cfg_min_mass - 1'b1));
               3:       mass = MASS_W'($urandom());
               default: mass = MASS_W'($urandom_range(cfg_min_mass, MASS_FULL));
            endcase
            send_frame(POS_W'(p), mass);
         end
      end
      gapless = 1'b0;
   endtask

   always @(posedge clock) begin
      drive_pair_t got;
      drive_pair_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (drive_queue.size() == 0) begin
            $display("%0t: drive transfer with none pending: left %0d right %0d",
                     $time, got.left, got.right);
            mismatches++;
         end else begin
            want = drive_queue.pop_front();
            if (got.left !== want.left) begin
               $display("%0t: left_drive expected %0d, got %0d", $time, want.left, got.left);
               mismatches++;
            end
            if (got.right !== want.right) begin
               $display("%0t: right_drive expected %0d, got %0d", $time, want.right, got.right);
               mismatches++;
            end
         end
      end
   end

   initial begin : rsp_sink
      int unsigned stall;
      while (reset) @(posedge clock);
      forever begin
         stall = gapless ? 0 : $urandom_range(0, MAX_GAP);
         if (rsp_holdoff != 0) begin
            stall = rsp_holdoff;
            rsp_holdoff = 0;
         end
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            do @(posedge clock); while (!rsp_tvalid);
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      end
   end

   initial begin
      #(TIMEOUT_CYCLES * 2 * CLK_HALF);
      $display("pose_history_steering_control_test: done, errors");
      $finish;
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_register_access();
      test_directed_frames();
      test_drive_saturation();
      test_output_backpressure();
      test_random_traffic();
      settle();
      if (mismatches == 0) begin
         $display("pose_history_steering_control_test: done, clean");
      end else begin
         $display("pose_history_steering_control_test: done, errors");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+design
design/phsc_pkg.sv
design/pose_history_steering_control.sv
bench/pose_history_steering_control_test.sv
